// ===== rtl/core/dsd_pkg.sv =====
`timescale 1ns / 1ps

package dsd_pkg;

  localparam logic [7:0]  ESC_BYTE        = 8'hFF;
  localparam logic [7:0]  FILL_BYTE       = 8'h00;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_BAD_ESCAPE = 2'd0,
    CAUSE_OVERFLOW   = 2'd1,
    CAUSE_EARLY_END  = 2'd2,
    CAUSE_INCOMPLETE = 2'd3
  } cause_t;

  // One decoded result as it travels from front to back
  typedef struct packed {
    logic [7:0]  data;
    kind_t       kind;
    cause_t      cause;
    logic [15:0] length;
  } result_t;

  // Per-buffer decoder state
  typedef struct packed {
    logic        escape_pending;
    logic [15:0] decoded_count;
    logic        discarding;
  } frame_state_t;

endpackage

// ===== rtl/core/dsd_front.sv =====
`timescale 1ns / 1ps

module dsd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic [15:0]         max_payload,
  output logic                res_valid,
  output dsd_pkg::result_t    res,
  output dsd_pkg::frame_state_t state
);
  import dsd_pkg::*;

  frame_state_t st_r, st_nxt;
  logic         do_emit;
  logic         do_err;
  logic [7:0]   emit_byte;
  cause_t       err_cause;

  // Classify the byte against the escape state; errors and emits resolved last
  always_comb begin
    st_nxt     = st_r;
    res_valid  = 1'b0;
    res.data   = 8'h00;
    res.kind   = KIND_DATA;
    res.cause  = CAUSE_BAD_ESCAPE;
    res.length = 16'h0000;
    do_emit    = 1'b0;
    do_err     = 1'b0;
    emit_byte  = in_byte;
    err_cause  = CAUSE_BAD_ESCAPE;

    if (st_r.discarding) begin
      if (in_last) begin
        st_nxt = '0;
      end
    end else if (st_r.escape_pending) begin
      st_nxt.escape_pending = 1'b0;
      if (in_byte == FILL_BYTE) begin
        do_emit   = 1'b1;
        emit_byte = ESC_BYTE;
      end else if (in_byte == ESC_BYTE) begin
        if (!in_last) begin
          do_err    = 1'b1;
          err_cause = CAUSE_EARLY_END;
        end else begin
          res_valid  = 1'b1;
          res.kind   = KIND_END;
          res.length = st_r.decoded_count;
          st_nxt     = '0;
        end
      end else begin
        do_err    = 1'b1;
        err_cause = CAUSE_BAD_ESCAPE;
      end
    end else if (in_byte == ESC_BYTE) begin
      if (in_last) begin
        do_err    = 1'b1;
        err_cause = CAUSE_INCOMPLETE;
      end else begin
        st_nxt.escape_pending = 1'b1;
      end
    end else begin
      do_emit = 1'b1;
    end

    if (do_emit) begin
      if (st_r.decoded_count >= max_payload) begin
        do_err    = 1'b1;
        err_cause = CAUSE_OVERFLOW;
      end else if (in_last) begin
        do_err    = 1'b1;
        err_cause = CAUSE_INCOMPLETE;
      end else begin
        st_nxt.decoded_count = st_r.decoded_count + 16'd1;
        res_valid            = 1'b1;
        res.kind             = KIND_DATA;
        res.data             = emit_byte;
      end
    end

    if (do_err) begin
      st_nxt            = '0;
      st_nxt.discarding = !in_last;
      res_valid         = 1'b1;
      res.kind          = KIND_ERROR;
      res.cause         = err_cause;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  assign state = st_r;

endmodule

// ===== rtl/core/dsd_queue.sv =====
`timescale 1ns / 1ps

module dsd_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dsd_pkg::result_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output dsd_pkg::result_t head_data
);
  import dsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  result_t          slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slots[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/dsd_back.sv =====
`timescale 1ns / 1ps

module dsd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  dsd_pkg::result_t head_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output dsd_pkg::kind_t   out_kind,
  output dsd_pkg::cause_t  out_error_cause,
  output logic [15:0]      out_frame_length
);
  import dsd_pkg::*;

  logic    valid_r;
  result_t hold_r;
  logic    load;

  // Refill the output register whenever it is empty or being drained
  assign load = !valid_r || out_ready;
  assign pop  = load && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold_r <= head_data;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = hold_r.data;
  assign out_kind         = hold_r.kind;
  assign out_error_cause  = hold_r.cause;
  assign out_frame_length = hold_r.length;

endmodule

// ===== rtl/core/byte_destuffing_deframer_unit.sv =====
`timescale 1ns / 1ps
// Escape-code deframer: takes one raw byte per cycle on the in_ channel
// (in_byte, in_last_of_buffer) and gives at most one result per byte on the
// out_ channel: a data byte, a frame end with its decoded length, or an error
// with its cause. 0xFF 0x00 decodes to 0xFF; 0xFF 0xFF ends the frame and is
// legal only on the buffer's last byte. After an error the rest of the buffer
// is dropped silently.
// Throughput: one byte per cycle while the queue has room. The decode step is
// combinational logic on the escape state; results go through a small queue
// into an output register.
// Stalls: when out_ready is low the output register holds and the queue fills;
// in_ready falls only when the queue (QUEUE_DEPTH items) is full.
// Configuration: cfg_max_payload is always ready and is written on
// cfg_valid; write it only while no bytes are in flight. Reset value 65535.
// Reset (rst_n low, synchronous): escape state, count and discard flag
// clear, the queue and output register empty; nothing is pending.
module byte_destuffing_deframer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last_of_buffer,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output dsd_pkg::kind_t   out_kind,
  output dsd_pkg::cause_t  out_error_cause,
  output logic [15:0]      out_frame_length,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_max_payload
);
  import dsd_pkg::*;

  logic [15:0]  max_payload_r;
  logic         in_fire;
  logic         res_valid;
  result_t      res;
  frame_state_t front_state;
  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_head_valid;
  result_t      q_head;

  // Configuration register: always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  // Accept while the queue has room; push only bytes that make a result
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign q_push   = in_fire && res_valid;

  dsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_byte     (in_byte),
    .in_last     (in_last_of_buffer),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res),
    .state       (front_state)
  );

  dsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (res),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  dsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_data        (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_kind         (out_kind),
    .out_error_cause  (out_error_cause),
    .out_frame_length (out_frame_length)
  );

  // A buffer's last byte always leaves the decoder clean
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_of_buffer |=>
      !front_state.escape_pending && !front_state.discarding &&
      front_state.decoded_count == 16'h0000)
    else $error("decoder state not cleared after last byte of buffer");

  // Dropped bytes never reach the queue
  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && front_state.discarding |-> !q_push)
    else $error("result pushed while discarding");

  // Never push into a full queue
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("queue overrun");

  // Error results carry no byte and no length
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |->
      out_byte == 8'h00 && out_frame_length == 16'h0000)
    else $error("error result with stray payload");

  // Escape pending and discarding never coexist
  a_state_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(front_state.escape_pending && front_state.discarding))
    else $error("escape pending while discarding");

endmodule
